// ===== rtl/tsk_pkg.sv =====
package tsk_pkg;

  // fixed field widths of the stream items
  localparam int unsigned VERTEX_W    = 6;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // defaults for the top level parameters
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF    = 1024;

  // vertex_count after reset
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // item kinds carried on the slave tuser
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

endpackage

// ===== rtl/tsk_ram.sv =====
module tsk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/topological_sort_kahn.sv =====
// Kahn topological sort. Edge items (tuser = 0) append one directed edge per
// cycle while idle to an edge memory of MAX_EDGES entries; an edge with an
// endpoint at or above the active vertex count, or one that arrives with the
// memory full, is dropped and remembered. A run item (tuser = 1) clears the
// in-degree memory, counts in-degrees over the stored edges, seeds the ready
// queue with the vertices of in-degree zero, then pops vertices; each pop
// walks the stored edges once and decrements the in-degree of every target
// of the popped vertex. All edge reads use the single read port of the edge
// memory. One result transaction leaves per emitted vertex, the final one
// with tlast, the cycle flag and the dropped-edge flag; a run that emits
// nothing returns one result with tuser = 0. No new item is taken while a run
// is in progress. vertex_count values above MAX_VERTICES act as MAX_VERTICES.
module topological_sort_kahn #(
  parameter int unsigned MAX_VERTICES = tsk_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = tsk_pkg::MAX_EDGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: vertex_count
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsk_pkg::COUNT_W-1:0]      cfg_data_i,
  // input items
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [tsk_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // from_vertex[5:0], to_vertex[11:6]
  input  logic                             s_axis_tuser_i,  // kind
  // results
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tsk_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,  // vertex[5:0], cycle_found[6],
                                                            // edges_dropped[7]
  output logic                             m_axis_tuser_o,  // has_vertex
  output logic                             m_axis_tlast_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = tsk_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_CNT_RD, ST_CNT_EDGE, ST_CNT_DEG, ST_SEED_RD, ST_SEED_CHK,
    ST_POP_RD, ST_POP_GET, ST_EMIT, ST_WALK_RD, ST_WALK_EDGE, ST_WALK_DEG, ST_FINAL
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   vcount_q;
  logic [EW-1:0]   total_q;
  logic [EW-1:0]   eidx_q;
  logic [VW:0]     scan_q;
  logic [VW:0]     head_q, tail_q;
  logic [VW:0]     emitted_q;
  logic            drop_q;
  logic [VW-1:0]   tgt_q;
  logic [VW-1:0]   node_q;
  logic            pend_q;
  logic [VW-1:0]   pend_v_q;

  logic            out_valid_q;
  logic [tsk_pkg::VERTEX_W-1:0] out_vertex_q;
  logic            out_has_q, out_last_q, out_cyc_q, out_drop_q;

  // active vertex count
  logic [CW-1:0]   n_w;
  assign n_w = (vcount_q > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vcount_q;

  // input fields
  logic [tsk_pkg::VERTEX_W-1:0] in_from_w, in_to_w;
  assign in_from_w = s_axis_tdata_i[5:0];
  assign in_to_w   = s_axis_tdata_i[11:6];

  logic in_acc_w;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc_w        = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  logic edge_ok_w;
  assign edge_ok_w = ({1'b0, in_from_w} < n_w) && ({1'b0, in_to_w} < n_w) &&
                     (total_q != EW'(MAX_EDGES));

  // memories
  logic            e_we;
  logic [2*VW-1:0] e_rdata;
  logic [VW-1:0]   e_src_w, e_tgt_w;
  logic            d_we;
  logic [VW-1:0]   d_waddr, d_raddr;
  logic [EW-1:0]   d_wdata, d_rdata;
  logic            f_we;
  logic [VW-1:0]   f_rdata;

  assign e_src_w = e_rdata[VW-1:0];
  assign e_tgt_w = e_rdata[2*VW-1:VW];

  assign e_we = in_acc_w && (s_axis_tuser_i == tsk_pkg::KIND_EDGE) && edge_ok_w;

  tsk_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (total_q[AW-1:0]),
    .wdata_i ({in_to_w[VW-1:0], in_from_w[VW-1:0]}),
    .raddr_i (eidx_q[AW-1:0]),
    .rdata_o (e_rdata)
  );

  tsk_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_degree_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  tsk_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (tail_q[VW-1:0]),
    .wdata_i ((state_q == ST_SEED_CHK) ? scan_q[VW-1:0] : tgt_q),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (f_rdata)
  );

  // walk match and range test of a stored edge
  logic walk_hit_w, cnt_ok_w;
  assign walk_hit_w = (e_src_w == node_q) && (CW'(e_tgt_w) < n_w);
  assign cnt_ok_w   = (CW'(e_src_w) < n_w) && (CW'(e_tgt_w) < n_w);

  // last edge of a scan
  logic edge_end_w;
  assign edge_end_w = ((eidx_q + EW'(1)) == total_q);

  // in-degree and ready-queue port steering
  always_comb begin
    d_we    = 1'b0;
    d_waddr = tgt_q;
    d_wdata = d_rdata;
    d_raddr = e_tgt_w;
    f_we    = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        d_we    = 1'b1;
        d_waddr = scan_q[VW-1:0];
        d_wdata = '0;
      end
      ST_CNT_DEG: begin
        d_we    = 1'b1;
        d_wdata = d_rdata + EW'(1);
      end
      ST_SEED_RD: begin
        d_raddr = scan_q[VW-1:0];
      end
      ST_SEED_CHK: begin
        f_we = (d_rdata == '0);
      end
      ST_WALK_DEG: begin
        d_we    = (d_rdata != '0);
        d_wdata = d_rdata - EW'(1);
        f_we    = (d_rdata == EW'(1)) && (tail_q != (VW+1)'(MAX_VERTICES));
      end
      default: begin
      end
    endcase
  end

  logic out_free_w;
  assign out_free_w = !out_valid_q || m_axis_tready_i;

  // a new result enters the output register this cycle
  logic out_load_w;
  assign out_load_w = out_free_w &&
                      ((state_q == ST_EMIT && pend_q) || state_q == ST_FINAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= tsk_pkg::VERTEX_COUNT_RST;
      total_q     <= '0;
      eidx_q      <= '0;
      scan_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      emitted_q   <= '0;
      drop_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_data_i;
      end
      if (m_axis_tready_i && !out_load_w) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc_w) begin
            if (s_axis_tuser_i == tsk_pkg::KIND_RUN) begin
              scan_q    <= '0;
              emitted_q <= '0;
              state_q   <= ST_CLR;
            end else if (edge_ok_w) begin
              total_q <= total_q + EW'(1);
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        ST_CLR: begin
          if (scan_q == (VW+1)'(MAX_VERTICES - 1)) begin
            eidx_q    <= '0;
            head_q    <= '0;
            tail_q    <= '0;
            emitted_q <= '0;
            pend_q    <= 1'b0;
            state_q   <= (total_q == '0) ? ST_SEED_RD : ST_CNT_RD;
            scan_q    <= '0;
          end else begin
            scan_q <= scan_q + (VW+1)'(1);
          end
        end
        ST_CNT_RD: state_q <= ST_CNT_EDGE;
        ST_CNT_EDGE: begin
          tgt_q <= e_tgt_w;
          if (cnt_ok_w) begin
            state_q <= ST_CNT_DEG;
          end else begin
            drop_q <= 1'b1;
            eidx_q <= eidx_q + EW'(1);
            state_q <= edge_end_w ? ST_SEED_RD : ST_CNT_RD;
          end
        end
        ST_CNT_DEG: begin
          eidx_q  <= eidx_q + EW'(1);
          state_q <= edge_end_w ? ST_SEED_RD : ST_CNT_RD;
        end
        ST_SEED_RD: begin
          // empty graph: skip seeding; the empty queue then leads to the final result
          state_q <= (n_w == '0) ? ST_POP_RD : ST_SEED_CHK;
        end
        ST_SEED_CHK: begin
          if (f_we) begin
            tail_q <= tail_q + (VW+1)'(1);
          end
          scan_q <= scan_q + (VW+1)'(1);
          state_q <= ((CW'(scan_q) + CW'(1)) == n_w) ? ST_POP_RD : ST_SEED_RD;
        end
        ST_POP_RD: begin
          if (head_q != tail_q) begin
            head_q  <= head_q + (VW+1)'(1);
            state_q <= ST_POP_GET;
          end else begin
            state_q <= ST_FINAL;
          end
        end
        ST_POP_GET: begin
          node_q    <= f_rdata;
          emitted_q <= emitted_q + (VW+1)'(1);
          state_q   <= ST_EMIT;
        end
        ST_EMIT: begin
          // the previous vertex goes out once a newer one proves it is not last
          if (!pend_q || out_free_w) begin
            if (pend_q) begin
              out_valid_q  <= 1'b1;
              out_vertex_q <= tsk_pkg::VERTEX_W'(pend_v_q);
              out_has_q    <= 1'b1;
              out_last_q   <= 1'b0;
              out_cyc_q    <= 1'b0;
              out_drop_q   <= 1'b0;
            end
            pend_q   <= 1'b1;
            pend_v_q <= node_q;
            eidx_q   <= '0;
            state_q  <= (total_q == '0) ? ST_POP_RD : ST_WALK_RD;
          end
        end
        ST_WALK_RD: state_q <= ST_WALK_EDGE;
        ST_WALK_EDGE: begin
          tgt_q <= e_tgt_w;
          if (walk_hit_w) begin
            state_q <= ST_WALK_DEG;
          end else begin
            eidx_q  <= eidx_q + EW'(1);
            state_q <= edge_end_w ? ST_POP_RD : ST_WALK_RD;
          end
        end
        ST_WALK_DEG: begin
          if (f_we) begin
            tail_q <= tail_q + (VW+1)'(1);
          end
          eidx_q  <= eidx_q + EW'(1);
          state_q <= edge_end_w ? ST_POP_RD : ST_WALK_RD;
        end
        ST_FINAL: begin
          if (out_free_w) begin
            out_valid_q  <= 1'b1;
            out_vertex_q <= pend_q ? tsk_pkg::VERTEX_W'(pend_v_q) : '0;
            out_has_q    <= pend_q;
            out_last_q   <= 1'b1;
            out_cyc_q    <= pend_q ? (CW'(emitted_q) < n_w) : (n_w != '0);
            out_drop_q   <= drop_q;
            total_q      <= '0;
            drop_q       <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_drop_q, out_cyc_q, out_vertex_q};
  assign m_axis_tuser_o  = out_has_q;
  assign m_axis_tlast_o  = out_last_q;

  // queue pointers stay ordered and bounded
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= (VW+1)'(MAX_VERTICES)))
    else $error("ready queue pointers out of order");

  // edge store never exceeds its capacity
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EW'(MAX_EDGES))
    else $error("edge count beyond capacity");

  // a run ends with an empty edge store and a cleared drop flag
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_free_w) |=> (total_q == '0 && !drop_q))
    else $error("edge store not cleared after run");

  // outside idle, never more vertices emitted than the active count
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(emitted_q) <= n_w || state_q == ST_IDLE)
    else $error("emitted more vertices than active");

endmodule
